@@ hdl/mer_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mer_pkg: shared types and constants of the midpoint ellipse rasterizer
// Holds the command opcodes, the fixed pixel and centre widths, and the
// pixel job that passes from the arithmetic core to the pixel emitter.
// ----------------------------------------------------------------------------
package mer_pkg;

    // Fixed field widths.
    localparam int CTR_W = 12;
    localparam int PIX_W = 14;

    // Command opcodes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // One point to be plotted in its four symmetric positions.
    typedef struct packed {
        logic [CTR_W-1:0] cx;
        logic [CTR_W-1:0] cy;
        logic [PIX_W-1:0] dx;
        logic [PIX_W-1:0] dy;
        logic             done;
    } t_pix_job;

endpackage
`default_nettype wire

@@ hdl/midpoint_ellipse_rasterizer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_unit: two-region midpoint ellipse rasterizer
// Input beats carry a start command (centre and radii) or a step command.
// Each step on an active ellipse yields four output beats, the symmetric
// pixels of the current point; the last beat of a step has last_of_run set,
// and all four beats of the final point (y = 0) carry done_res. Steps on an
// idle block and start commands produce no output.
// Input beats land in a two-entry queue. An accepted step passes the queue
// and the emitter's job register before it reaches the output. The
// sequencer drives its single shared multiplier through the start set-up
// states, the update states of a step (with an extra check in the first
// region) and the entry states on the step that crosses into the second
// region. The four output beats of one step overlap the core's update for the next.
// A stalled receiver holds the emitter; the core waits for the emitter and
// the queue fills, then the input is held off. Synchronous reset empties
// the queue and the emitter and leaves the block idle with no ellipse.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_unit #(
    parameter int RADIUS_BITS = 11
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_opcode,
    input  wire logic [mer_pkg::CTR_W-1:0]       i_center_x,
    input  wire logic [mer_pkg::CTR_W-1:0]       i_center_y,
    input  wire logic [RADIUS_BITS-1:0]          i_radius_x,
    input  wire logic [RADIUS_BITS-1:0]          i_radius_y,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [mer_pkg::PIX_W-1:0]     o_pixel_x,
    output logic signed [mer_pkg::PIX_W-1:0]     o_pixel_y,
    output logic                                 o_last_of_run,
    output logic                                 o_done_res
);

    logic                          cmd_valid, cmd_ready, cmd_start;
    logic [mer_pkg::CTR_W-1:0]     cmd_cx, cmd_cy;
    logic [RADIUS_BITS-1:0]        cmd_rx, cmd_ry;
    logic                          job_valid, job_ready;
    mer_pkg::t_pix_job             job;

    // Command intake and queue.
    mer_front #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius_x  (i_radius_x),
        .i_radius_y  (i_radius_y),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd_start (cmd_start),
        .o_cmd_cx    (cmd_cx),
        .o_cmd_cy    (cmd_cy),
        .o_cmd_rx    (cmd_rx),
        .o_cmd_ry    (cmd_ry)
    );

    // Ellipse state and arithmetic.
    mer_core #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd_start (cmd_start),
        .i_cmd_cx    (cmd_cx),
        .i_cmd_cy    (cmd_cy),
        .i_cmd_rx    (cmd_rx),
        .i_cmd_ry    (cmd_ry),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    // Four-beat pixel output.
    mer_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .o_job_ready   (job_ready),
        .i_job         (job),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_last_of_run (o_last_of_run),
        .o_done_res    (o_done_res)
    );

`ifndef SYNTHESIS
    // The four beats of one point share its done flag and follow without a gap.
    a_run_done_steady : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_of_run)
            |=> (o_valid && (o_done_res == $past(o_done_res))))
        else $error("done_res changed or output dropped inside one point");

    // No output beat is offered in the cycle after reset.
    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

@@ hdl/mer_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mer_front: command intake and queue
// Accepts input beats, classifies them as start or step commands and holds
// them in a two-entry queue so the intake and the core stall independently.
// ----------------------------------------------------------------------------
module mer_front #(
    parameter int RADIUS_BITS = 11
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_opcode,
    input  wire logic [mer_pkg::CTR_W-1:0]     i_center_x,
    input  wire logic [mer_pkg::CTR_W-1:0]     i_center_y,
    input  wire logic [RADIUS_BITS-1:0]        i_radius_x,
    input  wire logic [RADIUS_BITS-1:0]        i_radius_y,
    output logic                               o_cmd_valid,
    input  wire logic                          i_cmd_ready,
    output logic                               o_cmd_start,
    output logic [mer_pkg::CTR_W-1:0]          o_cmd_cx,
    output logic [mer_pkg::CTR_W-1:0]          o_cmd_cy,
    output logic [RADIUS_BITS-1:0]             o_cmd_rx,
    output logic [RADIUS_BITS-1:0]             o_cmd_ry
);

    localparam int QDEPTH = 2;

    logic                         r_q_op [QDEPTH];
    logic [mer_pkg::CTR_W-1:0]    r_q_cx [QDEPTH];
    logic [mer_pkg::CTR_W-1:0]    r_q_cy [QDEPTH];
    logic [RADIUS_BITS-1:0]       r_q_rx [QDEPTH];
    logic [RADIUS_BITS-1:0]       r_q_ry [QDEPTH];

    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       push, pop;

    // Handshakes on both sides of the queue.
    assign o_ready     = (r_count != 2'(QDEPTH));
    assign o_cmd_valid = (r_count != 2'd0);
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    // Head entry, decoded into a start flag.
    assign o_cmd_start = (r_q_op[r_rptr] == mer_pkg::OP_START);
    assign o_cmd_cx    = r_q_cx[r_rptr];
    assign o_cmd_cy    = r_q_cy[r_rptr];
    assign o_cmd_rx    = r_q_rx[r_rptr];
    assign o_cmd_ry    = r_q_ry[r_rptr];

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = push ? ~r_wptr : r_wptr;
        n_rptr  = pop ? ~r_rptr : r_rptr;
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_op[r_wptr] <= i_opcode;
            r_q_cx[r_wptr] <= i_center_x;
            r_q_cy[r_wptr] <= i_center_y;
            r_q_rx[r_wptr] <= i_radius_x;
            r_q_ry[r_wptr] <= i_radius_y;
        end
    end

endmodule
`default_nettype wire

@@ hdl/mer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mer_core: ellipse state and decision arithmetic
// Holds the current point and the two-region decision variables. A
// sequencer drives one shared registered multiplier through the start
// set-up, the per-step update and the entry into the second region.
// ----------------------------------------------------------------------------
module mer_core #(
    parameter int RADIUS_BITS = 11
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    output logic                               o_cmd_ready,
    input  wire logic                          i_cmd_start,
    input  wire logic [mer_pkg::CTR_W-1:0]     i_cmd_cx,
    input  wire logic [mer_pkg::CTR_W-1:0]     i_cmd_cy,
    input  wire logic [RADIUS_BITS-1:0]        i_cmd_rx,
    input  wire logic [RADIUS_BITS-1:0]        i_cmd_ry,
    output logic                               o_job_valid,
    input  wire logic                          i_job_ready,
    output mer_pkg::t_pix_job                  o_job
);

    localparam int R  = RADIUS_BITS;
    localparam int XW = R + 1;          // point x may pass the radius by one
    localparam int QW = 2 * R;          // squared radius
    localparam int SW = 3 * R + 2;      // step_a, step_b
    localparam int MW = 2 * R + 2;      // multiplier operand
    localparam int PW = 2 * MW;         // multiplier product
    localparam int DW = 4 * R + 6;      // decision, sign in the top bit
    localparam int EW = XW + mer_pkg::PIX_W;

    // Sequencer states.
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ST_RX2 = 5'd1;
    localparam logic [4:0] S_ST_RY2 = 5'd2;
    localparam logic [4:0] S_ST_RXY = 5'd3;
    localparam logic [4:0] S_ST_FIN = 5'd4;
    localparam logic [4:0] S_UA     = 5'd5;
    localparam logic [4:0] S_UB     = 5'd6;
    localparam logic [4:0] S_UC     = 5'd7;
    localparam logic [4:0] S_UD     = 5'd8;
    localparam logic [4:0] S_UE     = 5'd9;
    localparam logic [4:0] S_E1     = 5'd10;
    localparam logic [4:0] S_E2     = 5'd11;
    localparam logic [4:0] S_E3     = 5'd12;
    localparam logic [4:0] S_E4     = 5'd13;
    localparam logic [4:0] S_E5     = 5'd14;
    localparam logic [4:0] S_E6     = 5'd15;
    localparam logic [4:0] S_E7     = 5'd16;

    logic [4:0]               r_state, n_state;
    logic                     r_active, n_active;
    logic                     r_in2, n_in2;

    logic                     r_neg;
    logic [XW-1:0]            r_px;
    logic [R-1:0]             r_py;
    logic [SW-1:0]            r_step_a;
    logic [SW-1:0]            r_step_b;
    logic [DW-1:0]            r_dec;
    logic [mer_pkg::CTR_W-1:0] r_cx;
    logic [mer_pkg::CTR_W-1:0] r_cy;
    logic [R-1:0]             r_rx;
    logic [R-1:0]             r_ry;
    logic [QW-1:0]            r_rx2;
    logic [QW-1:0]            r_ry2;
    logic [PW-1:0]            r_prod;
    logic [MW-1:0]            r_t1, r_t2, r_t3;

    logic                     idle, cmd_take, neg;
    logic [MW-1:0]            mul_a, mul_b;
    logic [PW-1:0]            mul_p;
    logic [R+1:0]             tx;
    logic [R-1:0]             ty;
    logic [SW-1:0]            prod2;
    logic [DW-1:0]            sb_r1, r1_dec, r2_term, r2_dec;
    logic [EW-1:0]            px_ext, py_ext;

    assign idle     = (r_state == S_IDLE);
    assign neg      = r_dec[DW-1];
    assign cmd_take = i_cmd_valid && o_cmd_ready;

    // A step on an active ellipse needs room in the emitter; other commands do not.
    assign o_cmd_ready = idle && (i_cmd_start || !r_active || i_job_ready);
    assign o_job_valid = idle && i_cmd_valid && !i_cmd_start && r_active;

    // Pixel job built from the current point.
    assign px_ext = EW'(r_px);
    assign py_ext = EW'(r_py);
    always_comb begin
        o_job.cx   = r_cx;
        o_job.cy   = r_cy;
        o_job.dx   = px_ext[mer_pkg::PIX_W-1:0];
        o_job.dy   = py_ext[mer_pkg::PIX_W-1:0];
        o_job.done = (r_py == '0);
    end

    // Second-region entry terms; below y = 1 the offset y - 1 squares to one.
    assign tx = {r_px, 1'b1};
    assign ty = (r_py == '0) ? R'(1) : r_py - R'(1);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_ST_RX2: begin mul_a = MW'(r_rx);  mul_b = MW'(r_rx); end
            S_ST_RY2: begin mul_a = MW'(r_ry);  mul_b = MW'(r_ry); end
            S_ST_RXY: begin mul_a = MW'(r_rx2); mul_b = MW'(r_ry); end
            S_UB:     begin mul_a = MW'(r_ry2); mul_b = MW'(r_px); end
            S_UC:     begin mul_a = MW'(r_rx2); mul_b = MW'(r_py); end
            S_E1:     begin mul_a = MW'(r_ry);  mul_b = MW'(tx);   end
            S_E2:     begin mul_a = MW'(r_rx);  mul_b = MW'(ty);   end
            S_E3:     begin mul_a = MW'(r_rx);  mul_b = MW'(r_ry); end
            S_E4:     begin mul_a = r_t1;       mul_b = r_t1;      end
            S_E5:     begin mul_a = r_t2;       mul_b = r_t2;      end
            S_E6:     begin mul_a = r_t3;       mul_b = r_t3;      end
            default:  begin mul_a = '0;         mul_b = '0;        end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Decision updates of the two regions.
    assign prod2   = SW'({r_prod, 1'b0});
    assign sb_r1   = r_neg ? '0 : DW'(prod2);
    assign r1_dec  = r_dec + DW'(r_step_a) + DW'(r_ry2) - sb_r1;
    assign r2_term = (r_neg ? DW'(r_step_a) : '0) - DW'(prod2) + DW'(r_rx2);
    assign r2_dec  = r_dec + (r2_term << 2);

    // Sequencer control.
    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_in2    = r_in2;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_take) begin
                    if (i_cmd_start) begin
                        n_active = 1'b1;
                        n_in2    = 1'b0;
                        n_state  = S_ST_RX2;
                    end else if (r_active) begin
                        if (r_py == '0) begin
                            n_active = 1'b0;
                        end else begin
                            n_state = S_UA;
                        end
                    end
                end
            end
            S_ST_RX2: n_state = S_ST_RY2;
            S_ST_RY2: n_state = S_ST_RXY;
            S_ST_RXY: n_state = S_ST_FIN;
            S_ST_FIN: n_state = S_IDLE;
            S_UA:     n_state = S_UB;
            S_UB:     n_state = S_UC;
            S_UC:     n_state = S_UD;
            S_UD:     n_state = r_in2 ? S_IDLE : S_UE;
            S_UE:     n_state = (r_step_a > r_step_b) ? S_E1 : S_IDLE;
            S_E1:     n_state = S_E2;
            S_E2:     n_state = S_E3;
            S_E3:     n_state = S_E4;
            S_E4:     n_state = S_E5;
            S_E5:     n_state = S_E6;
            S_E6:     n_state = S_E7;
            S_E7: begin
                n_in2   = 1'b1;
                n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_in2    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_in2    <= n_in2;
        end
    end

    // Datapath registers, loaded as the sequencer walks its states.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: begin
                if (cmd_take && i_cmd_start) begin
                    r_cx     <= i_cmd_cx;
                    r_cy     <= i_cmd_cy;
                    r_rx     <= i_cmd_rx;
                    r_ry     <= i_cmd_ry;
                    r_px     <= '0;
                    r_py     <= i_cmd_ry;
                    r_step_a <= '0;
                end
            end
            S_ST_RY2: r_rx2 <= r_prod[QW-1:0];
            S_ST_RXY: r_ry2 <= r_prod[QW-1:0];
            S_ST_FIN: begin
                r_step_b <= prod2;
                r_dec    <= DW'(r_ry2) - DW'(r_prod) + DW'(r_rx2 >> 2);
            end
            S_UA: begin
                r_neg <= neg;
                if (!r_in2) begin
                    r_px <= r_px + XW'(1);
                    if (!neg) begin
                        r_py <= r_py - R'(1);
                    end
                end else begin
                    r_py <= r_py - R'(1);
                    if (neg) begin
                        r_px <= r_px + XW'(1);
                    end
                end
            end
            S_UC: begin
                if (!r_in2 || r_neg) begin
                    r_step_a <= prod2;
                end
            end
            S_UD: begin
                if (r_in2) begin
                    r_step_b <= prod2;
                    r_dec    <= r2_dec;
                end else begin
                    if (!r_neg) begin
                        r_step_b <= prod2;
                    end
                    r_dec <= r1_dec;
                end
            end
            S_E2: r_t1  <= r_prod[MW-1:0];
            S_E3: r_t2  <= r_prod[MW-1:0];
            S_E4: r_t3  <= r_prod[MW-1:0];
            S_E5: r_dec <= DW'(r_prod);
            S_E6: r_dec <= r_dec + (DW'(r_prod) << 2);
            S_E7: r_dec <= r_dec - (DW'(r_prod) << 2);
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/mer_emit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mer_emit: pixel emitter
// Holds one pixel job and sends its four quadrant-symmetric pixels as four
// output beats, taking the next job as the last beat leaves.
// ----------------------------------------------------------------------------
module mer_emit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_job_valid,
    output logic                                 o_job_ready,
    input  wire mer_pkg::t_pix_job               i_job,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [mer_pkg::PIX_W-1:0]     o_pixel_x,
    output logic signed [mer_pkg::PIX_W-1:0]     o_pixel_y,
    output logic                                 o_last_of_run,
    output logic                                 o_done_res
);

    localparam logic [1:0] BEAT_LAST = 2'd3;

    logic                          r_busy;
    logic [1:0]                    r_idx;
    mer_pkg::t_pix_job             r_job;
    logic                          beat_take, job_take, is_last;
    logic [mer_pkg::PIX_W-1:0]     cx_ext, cy_ext, sum_x, sum_y;

    assign is_last     = (r_idx == BEAT_LAST);
    assign beat_take   = r_busy && i_ready;
    assign o_job_ready = !r_busy || (beat_take && is_last);
    assign job_take    = i_job_valid && o_job_ready;

    // Beat order: (+x,+y), (-x,+y), (+x,-y), (-x,-y).
    assign cx_ext = mer_pkg::PIX_W'(r_job.cx);
    assign cy_ext = mer_pkg::PIX_W'(r_job.cy);
    assign sum_x  = r_idx[0] ? cx_ext - r_job.dx : cx_ext + r_job.dx;
    assign sum_y  = r_idx[1] ? cy_ext - r_job.dy : cy_ext + r_job.dy;

    assign o_valid       = r_busy;
    assign o_pixel_x     = signed'(sum_x);
    assign o_pixel_y     = signed'(sum_y);
    assign o_last_of_run = is_last;
    assign o_done_res    = r_job.done;

    // Beat counter and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (job_take) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (beat_take && is_last) begin
            r_busy <= 1'b0;
        end else if (beat_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // Job payload.
    always_ff @(posedge i_clk) begin
        if (job_take) begin
            r_job <= i_job;
        end
    end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: midpoint ellipse rasterizer unit
// Drives start and step beats into the rasterizer, predicts the four pixel
// beats of every productive step with an integer model kept in the bench,
// and checks each output beat field by field in arrival order. Both sides
// idle at random; one phase runs flat out and one holds the output off long
// enough to back the input up.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RB           = 11;
    localparam int IDLE_PCT     = 37;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 40;

    // One expected output beat.
    typedef struct packed {
        logic [mer_pkg::PIX_W-1:0] px;
        logic [mer_pkg::PIX_W-1:0] py;
        logic                      last;
        logic                      done;
    } t_pixel_beat;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic                             i_opcode;
    logic [mer_pkg::CTR_W-1:0]        i_center_x;
    logic [mer_pkg::CTR_W-1:0]        i_center_y;
    logic [RB-1:0]                    i_radius_x;
    logic [RB-1:0]                    i_radius_y;
    logic                             o_valid;
    logic                             i_ready;
    logic signed [mer_pkg::PIX_W-1:0] o_pixel_x;
    logic signed [mer_pkg::PIX_W-1:0] o_pixel_y;
    logic                             o_last_of_run;
    logic                             o_done_res;

    // Expected pixel beats, oldest first.
    t_pixel_beat pending_pixels[$];
    t_pixel_beat want_beat;
    int          err_count = 0;

    // Traffic shaping controls shared by the test tasks and the drivers.
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    int   hold_seq  = 0;

    // Tracing state of the ellipse as the bench sees it.
    logic [63:0]               cur_x     = '0;
    logic [63:0]               cur_y     = '0;
    logic [63:0]               dec_val   = '0;
    logic [63:0]               grad_x    = '0;
    logic [63:0]               grad_y    = '0;
    logic                      in_region2 = 1'b0;
    logic                      drawing   = 1'b0;
    logic [mer_pkg::CTR_W-1:0] org_x     = '0;
    logic [mer_pkg::CTR_W-1:0] org_y     = '0;
    logic [RB-1:0]             semi_x    = '0;
    logic [RB-1:0]             semi_y    = '0;

    midpoint_ellipse_rasterizer_unit #(
        .RADIUS_BITS(RB)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius_x    (i_radius_x),
        .i_radius_y    (i_radius_y),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_last_of_run (o_last_of_run),
        .o_done_res    (o_done_res)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or loses beats.
    initial begin
        #400_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Builds one pixel beat from full-width sums, keeping the low bits.
    function automatic t_pixel_beat make_beat(input logic [63:0] px, input logic [63:0] py,
                                              input logic last, input logic done);
        t_pixel_beat b;
        b.px   = px[mer_pkg::PIX_W-1:0];
        b.py   = py[mer_pkg::PIX_W-1:0];
        b.last = last;
        b.done = done;
        return b;
    endfunction

    // Applies one accepted input beat to the tracing state and queues the
    // pixel beats it produces.
    task automatic advance_ellipse(input logic op, input logic [mer_pkg::CTR_W-1:0] cx,
                                   input logic [mer_pkg::CTR_W-1:0] cy,
                                   input logic [RB-1:0] rx, input logic [RB-1:0] ry);
        logic [63:0] rx64, ry64, rx2, ry2, ox, oy, tx, ty;
        logic        fin;
        if (op == mer_pkg::OP_START) begin
            org_x      = cx;
            org_y      = cy;
            semi_x     = rx;
            semi_y     = ry;
            rx64       = 64'(rx);
            ry64       = 64'(ry);
            cur_x      = '0;
            cur_y      = ry64;
            in_region2 = 1'b0;
            drawing    = 1'b1;
            grad_x     = '0;
            grad_y     = 64'd2 * rx64 * rx64 * ry64;
            dec_val    = ry64 * ry64 - rx64 * rx64 * ry64 + ((rx64 * rx64) >> 2);
        end else if (drawing) begin
            ox  = 64'(org_x);
            oy  = 64'(org_y);
            fin = (cur_y == 64'd0);
            pending_pixels.push_back(make_beat(ox + cur_x, oy + cur_y, 1'b0, fin));
            pending_pixels.push_back(make_beat(ox - cur_x, oy + cur_y, 1'b0, fin));
            pending_pixels.push_back(make_beat(ox + cur_x, oy - cur_y, 1'b0, fin));
            pending_pixels.push_back(make_beat(ox - cur_x, oy - cur_y, 1'b1, fin));
            rx2 = 64'(semi_x) * 64'(semi_x);
            ry2 = 64'(semi_y) * 64'(semi_y);
            if (fin) begin
                drawing = 1'b0;
            end else if (!in_region2) begin
                // First region: x always moves, y moves when the sign says so.
                cur_x = cur_x + 64'd1;
                if (dec_val[63]) begin
                    grad_x  = 64'd2 * ry2 * cur_x;
                    dec_val = dec_val + grad_x + ry2;
                end else begin
                    cur_y   = cur_y - 64'd1;
                    grad_x  = 64'd2 * ry2 * cur_x;
                    grad_y  = 64'd2 * rx2 * cur_y;
                    dec_val = dec_val + grad_x - grad_y + ry2;
                end
                // Crossing into the second region restarts the decision,
                // scaled by four so the half-pixel term stays exact.
                if (grad_x > grad_y) begin
                    tx         = 64'd2 * cur_x + 64'd1;
                    ty         = cur_y - 64'd1;
                    in_region2 = 1'b1;
                    dec_val    = ry2 * tx * tx + 64'd4 * rx2 * (ty * ty)
                                 - 64'd4 * rx2 * ry2;
                end
            end else begin
                // Second region: y always moves, x moves when the sign says so.
                cur_y = cur_y - 64'd1;
                if (dec_val[63]) begin
                    cur_x   = cur_x + 64'd1;
                    grad_x  = 64'd2 * ry2 * cur_x;
                    grad_y  = 64'd2 * rx2 * cur_y;
                    dec_val = dec_val + 64'd4 * (grad_x - grad_y + rx2);
                end else begin
                    grad_y  = 64'd2 * rx2 * cur_y;
                    dec_val = dec_val + 64'd4 * (rx2 - grad_y);
                end
            end
        end
    endtask

    // Prints one line per mismatch and counts all of them.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
    endtask

    // Offers one input beat, waits for it to be taken, then predicts it.
    task automatic send_beat(input logic op, input logic [mer_pkg::CTR_W-1:0] cx,
                             input logic [mer_pkg::CTR_W-1:0] cy, input logic [RB-1:0] rx,
                             input logic [RB-1:0] ry);
        if (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius_x <= rx;
        i_radius_y <= ry;
        do @(posedge i_clk); while (!o_ready);
        advance_ellipse(op, cx, cy, rx, ry);
    endtask

    // Output ready: random idling, a steady mode, and long hold-offs.
    initial begin : ready_driver
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq  = 0;
        i_ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen_seq) begin
                seen_seq  = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (rx_steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compares every accepted output beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected beat", 64'(o_pixel_x), '0);
            end else begin
                want_beat = pending_pixels.pop_front();
                if (o_pixel_x !== want_beat.px)
                    report_mismatch("pixel_x", 64'(o_pixel_x), 64'(want_beat.px));
                if (o_pixel_y !== want_beat.py)
                    report_mismatch("pixel_y", 64'(o_pixel_y), 64'(want_beat.py));
                if (o_last_of_run !== want_beat.last)
                    report_mismatch("last_of_run", 64'(o_last_of_run), 64'(want_beat.last));
                if (o_done_res !== want_beat.done)
                    report_mismatch("done_res", 64'(o_done_res), 64'(want_beat.done));
            end
        end
    end

    // Steps before any ellipse is loaded must be ignored.
    task automatic test_step_while_idle();
        send_beat(mer_pkg::OP_STEP, 12'd5, 12'd7, 11'd3, 11'd4);
        send_beat(mer_pkg::OP_STEP, 12'hFFF, 12'hFFF, 11'h7FF, 11'h7FF);
    endtask

    // Zero radii: a lone final point, and a vertical line.
    task automatic test_degenerate_radii();
        int k;
        send_beat(mer_pkg::OP_START, 12'd0, 12'd0, 11'd0, 11'd0);
        send_beat(mer_pkg::OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0);
        // A step after the final point produces nothing.
        send_beat(mer_pkg::OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0);
        send_beat(mer_pkg::OP_START, 12'hFFF, 12'hFFF, 11'd0, 11'd3);
        for (k = 0; k < 5; k++)
            send_beat(mer_pkg::OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0);
        send_beat(mer_pkg::OP_START, 12'd100, 12'hFFF, 11'd5, 11'd0);
        send_beat(mer_pkg::OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0);
    endtask

    // Largest radii at the low edge of the centre range, a tall narrow ellipse at
    // the high edge, and a restart while an ellipse is still being traced.
    task automatic test_extreme_radii();
        int k;
        send_beat(mer_pkg::OP_START, 12'd0, 12'd0, 11'h7FF, 11'h7FF);
        for (k = 0; k < 3; k++)
            send_beat(mer_pkg::OP_STEP, 12'hFFF, 12'hFFF, 11'h7FF, 11'h7FF);
        send_beat(mer_pkg::OP_START, 12'hFFF, 12'hFFF, 11'd1, 11'h7FF);
        for (k = 0; k < 3; k++)
            send_beat(mer_pkg::OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0);
    endtask

    // Output held off for a long stretch while steps keep coming.
    task automatic test_output_backpressure();
        int k;
        hold_seq++;
        send_beat(mer_pkg::OP_START, 12'd2000, 12'd1000, 11'd9, 11'd6);
        for (k = 0; k < 10; k++)
            send_beat(mer_pkg::OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0);
    endtask

    // A whole ellipse with no idling on either side.
    task automatic test_full_rate();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_beat(mer_pkg::OP_START, 12'd1500, 12'd2500, 11'd15, 11'd12);
        while (drawing)
            send_beat(mer_pkg::OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Mostly whole ellipses of small size with random content, some cut
    // short or oversized, mixed with random noise beats.
    task automatic test_random_traffic();
        int            counted;
        int            budget;
        logic          op;
        logic [RB-1:0] rx, ry;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(9) == 0) begin
                    rx     = RB'($urandom_range(2047));
                    ry     = RB'($urandom_range(2047));
                    budget = $urandom_range(2, 8);
                end else begin
                    rx     = RB'($urandom_range(12));
                    ry     = RB'($urandom_range(12));
                    budget = ($urandom_range(4) == 0) ? $urandom_range(1, 6) : 100000;
                end
                send_beat(mer_pkg::OP_START, mer_pkg::CTR_W'($urandom_range(4095)),
                          mer_pkg::CTR_W'($urandom_range(4095)), rx, ry);
                counted++;
                while (drawing && budget > 0) begin
                    send_beat(mer_pkg::OP_STEP, mer_pkg::CTR_W'($urandom_range(4095)),
                              mer_pkg::CTR_W'($urandom_range(4095)),
                              RB'($urandom_range(2047)), RB'($urandom_range(2047)));
                    counted++;
                    budget--;
                end
                if (!drawing && $urandom_range(3) == 0) begin
                    send_beat(mer_pkg::OP_STEP, '0, '0, '0, '0);
                    counted++;
                end
            end else begin
                op = ($urandom_range(1) == 1) ? mer_pkg::OP_STEP : mer_pkg::OP_START;
                counted++;
                send_beat(op, mer_pkg::CTR_W'($urandom_range(4095)),
                          mer_pkg::CTR_W'($urandom_range(4095)),
                          RB'($urandom_range(2047)), RB'($urandom_range(2047)));
            end
        end
    endtask

    // Reset, run the tests in turn, drain and judge.
    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_opcode   = mer_pkg::OP_START;
        i_center_x = '0;
        i_center_y = '0;
        i_radius_x = '0;
        i_radius_y = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_step_while_idle();
        test_degenerate_radii();
        test_extreme_radii();
        test_output_backpressure();
        test_full_rate();
        test_random_traffic();

        i_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
